>>> src/ls2p_pkg.sv
package ls2p_pkg;

	// Default number of CORDIC micro-rotations.
	localparam int CordicStagesDef = 24;

	// CORDIC gain 0.60725293500888 in Q30.
	localparam int GainW = 30;
	localparam logic [GainW-1:0] CORDIC_GAIN_Q30 = 30'd652032874;

	// Rounded atan(2^-i) in binary angle units (full turn = 2^32).
	localparam int AtanW = 30;
	localparam logic [AtanW-1:0] ATAN_TAB [32] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81,
		30'd41,        30'd20,        30'd10,        30'd5,
		30'd3,         30'd1,         30'd1,         30'd0
	};

	localparam int RangeW = 24;
	localparam int CoordW = 32;
	localparam int AngleW = 32;
	localparam int CfgIdxW = 8;
	localparam int CfgDataW = 32;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		REG_START_ANGLE = 8'd0,
		REG_ANGLE_STEP  = 8'd1,
		REG_RANGE_LO    = 8'd2,
		REG_RANGE_HI    = 8'd3,
		REG_NEAR_LIMIT  = 8'd4,
		REG_MOUNT_X     = 8'd5,
		REG_MOUNT_Y     = 8'd6,
		REG_MOUNT_YAW   = 8'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [RangeW-1:0] range;
		logic              range_finite;
		logic              first_beam;
		logic              last_beam;
	} beam_t;

	typedef struct packed {
		logic signed [CoordW-1:0] point_x;
		logic signed [CoordW-1:0] point_y;
		logic                     scan_end;
	} point_t;

endpackage

>>> src/laser_scan_to_points.sv
// Converts laser scan beams into points in the base frame. Each accepted beam takes its angle
// from start_angle on a scan's first beam, otherwise from the running beam angle, which then
// advances by angle_step. A beam that is not finite, or whose range lies outside
// [range_lo, range_hi] or not above near_limit, is dropped: it produces no transfer on the
// point channel. A kept beam is rotated by beam angle plus mount_yaw with a single iterative
// CORDIC unit and shifted by the mount offset, with both coordinates saturated to 32 bits.
// A kept beam holds the beam channel stalled after its transfer through a multiply step, a
// set-up step, one micro-rotation per cycle and a rounding step, so no new beam is taken
// until the last one is through; the rounding step waits further only if the previous point
// still sits unaccepted in the output register. Configuration writes are always taken.
module laser_scan_to_points
	import ls2p_pkg::*;
#(
	parameter int CORDIC_STAGES = CordicStagesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                beam_valid,
	output logic                beam_stall,
	input  beam_t               beam,
	output logic                point_valid,
	input  logic                point_stall,
	output point_t              point,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	// Datapath widths. The rotated vector never exceeds about 2^54 in Q30, so 57 bits leave
	// headroom for the floor shifts. The residual angle stays well inside 34 bits.
	localparam int ProdW = RangeW + GainW;
	localparam int XW    = ProdW + 3;
	localparam int ZW    = AngleW + 2;
	localparam int SumW  = CoordW + 2;
	localparam int RndW  = XW - 30;
	localparam int CntW  = $clog2(CORDIC_STAGES);

	// One-hot sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_PREP = 5'b00100,
		ST_ROT  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [AngleW-1:0]        start_angle_q;
	logic [AngleW-1:0]        angle_step_q;
	logic [RangeW-1:0]        range_lo_q;
	logic [RangeW-1:0]        range_hi_q;
	logic [RangeW-1:0]        near_limit_q;
	logic signed [CoordW-1:0] mount_x_q;
	logic signed [CoordW-1:0] mount_y_q;
	logic [AngleW-1:0]        mount_yaw_q;

	// Beam state and working registers.
	logic [AngleW-1:0]    beam_angle_q;
	logic [AngleW-1:0]    theta_q;
	logic [RangeW-1:0]    range_q;
	logic                 last_q;
	logic [ProdW-1:0]     prod_q;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic signed [ZW-1:0] z_q;
	logic [CntW-1:0]      cnt_q;

	logic   point_valid_q;
	point_t point_q;

	logic              beam_xfer;
	logic              keep;
	logic [AngleW-1:0] angle_cur;
	logic              flip;
	logic [AngleW-1:0] theta_adj;
	logic [XW-1:0]     prod_ext;

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	logic signed [ZW-1:0] atan_ext;
	logic                 rot_last;

	logic signed [XW-1:0]     x_bias;
	logic signed [XW-1:0]     y_bias;
	logic signed [SumW-1:0]   x_sum;
	logic signed [SumW-1:0]   y_sum;
	logic signed [CoordW-1:0] x_sat;
	logic signed [CoordW-1:0] y_sat;
	logic                     out_free;

	function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [SumW-1:0] v);
		logic hi_ok;
		logic lo_ok;
		hi_ok = (v[SumW-1:CoordW-1] == '0);
		lo_ok = (v[SumW-1:CoordW-1] == '1);
		if (hi_ok || lo_ok) begin
			sat_coord = v[CoordW-1:0];
		end else if (v[SumW-1]) begin
			sat_coord = {1'b1, {(CoordW-1){1'b0}}};
		end else begin
			sat_coord = {1'b0, {(CoordW-1){1'b1}}};
		end
	endfunction

	// The beam channel is only open while the sequencer is idle.
	assign beam_stall = (state_q != ST_IDLE);
	assign beam_xfer  = beam_valid && !beam_stall;
	assign cfg_ready  = 1'b1;

	assign angle_cur = beam.first_beam ? start_angle_q : beam_angle_q;
	assign keep = beam.range_finite && (beam.range >= range_lo_q) &&
	              (beam.range <= range_hi_q) && (beam.range > near_limit_q);

	// An angle in the left half plane, [2^30, 3*2^30), is brought into range by a half turn,
	// which is a negation of the start vector.
	assign flip      = theta_q[AngleW-1] ^ theta_q[AngleW-2];
	assign theta_adj = {theta_q[AngleW-1] ^ flip, theta_q[AngleW-2:0]};
	assign prod_ext  = {{(XW-ProdW){1'b0}}, prod_q};

	// Shared micro-rotation: two floor shifts by the stage number and one table lookup.
	assign dx       = y_q >>> cnt_q;
	assign dy       = x_q >>> cnt_q;
	assign atan_ext = ZW'(ATAN_TAB[5'(cnt_q)]);
	assign rot_last = (cnt_q == CntW'(CORDIC_STAGES - 1));

	// Round to nearest with halves upwards, add the mount offset and saturate. The rounded
	// coordinate is signed, so it is sign extended before the offset is added.
	assign x_bias = x_q + (XW'(1) <<< 29);
	assign y_bias = y_q + (XW'(1) <<< 29);
	assign x_sum  = SumW'($signed(x_bias[XW-1:XW-RndW])) + SumW'(mount_x_q);
	assign y_sum  = SumW'($signed(y_bias[XW-1:XW-RndW])) + SumW'(mount_y_q);
	assign x_sat  = sat_coord(x_sum);
	assign y_sat  = sat_coord(y_sum);

	// The output register can take a new point when it is empty or being emptied.
	assign out_free = !point_valid_q || !point_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= '0;
			angle_step_q  <= '0;
			range_lo_q    <= '0;
			range_hi_q    <= '1;
			near_limit_q  <= RangeW'(41);
			mount_x_q     <= '0;
			mount_y_q     <= '0;
			mount_yaw_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_ANGLE: start_angle_q <= cfg_data;
				REG_ANGLE_STEP:  angle_step_q  <= cfg_data;
				REG_RANGE_LO:    range_lo_q    <= cfg_data[RangeW-1:0];
				REG_RANGE_HI:    range_hi_q    <= cfg_data[RangeW-1:0];
				REG_NEAR_LIMIT:  near_limit_q  <= cfg_data[RangeW-1:0];
				REG_MOUNT_X:     mount_x_q     <= cfg_data;
				REG_MOUNT_Y:     mount_y_q     <= cfg_data;
				REG_MOUNT_YAW:   mount_yaw_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			beam_angle_q  <= '0;
			point_valid_q <= 1'b0;
		end else begin
			// A finished point fills the output register; otherwise it empties on a transfer.
			if (state_q == ST_FIN && out_free) begin
				point_valid_q <= 1'b1;
			end else if (!point_stall) begin
				point_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (beam_xfer) begin
						beam_angle_q <= angle_cur + angle_step_q;
						if (keep) begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL:  state_q <= ST_PREP;
				ST_PREP: state_q <= ST_ROT;
				ST_ROT: begin
					if (rot_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers carry no reset: they are always loaded before use.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				theta_q <= angle_cur + mount_yaw_q;
				range_q <= beam.range;
				last_q  <= beam.last_beam;
			end
			ST_MUL: begin
				prod_q <= range_q * CORDIC_GAIN_Q30;
			end
			ST_PREP: begin
				x_q   <= flip ? -$signed(prod_ext) : $signed(prod_ext);
				y_q   <= '0;
				z_q   <= ZW'($signed(theta_adj));
				cnt_q <= '0;
			end
			ST_ROT: begin
				if (z_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_ext;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_ext;
				end
				cnt_q <= cnt_q + CntW'(1);
			end
			ST_FIN: begin
				if (out_free) begin
					point_q.point_x  <= x_sat;
					point_q.point_y  <= y_sat;
					point_q.scan_end <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign point_valid = point_valid_q;
	assign point       = point_q;

	// A kept beam always starts the multiply step in the next cycle.
	a_kept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		beam_xfer && keep |=> state_q == ST_MUL)
		else $error("kept beam did not start the rotation");

	// A dropped beam produces no work and leaves the channel open.
	a_drop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		beam_xfer && !keep |=> state_q == ST_IDLE)
		else $error("dropped beam started the rotation");

	// The running angle advances by exactly one step for every beam, kept or dropped.
	a_angle_adv: assert property (@(posedge clk) disable iff (!arst_n)
		beam_xfer |=> beam_angle_q == $past(angle_cur + angle_step_q))
		else $error("beam angle did not advance");

	// A new point only appears on leaving the rounding state.
	a_point_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(point_valid_q) |-> $past(state_q == ST_FIN))
		else $error("point produced outside the rounding state");

	// The rotation state always leaves after the configured number of stages.
	a_rot_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROT && rot_last |=> state_q == ST_FIN)
		else $error("rotation overran its stage count");

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

endmodule
